/* hw/rtl/assert_macros.svh */
// Assertion macros used by the sgd_momentum_weight_update RTL.
// No dependencies; the including file supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent property, disabled while reset is high.
`define SGDM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sgdm assertion failed");

// Antecedent in one cycle, consequent in the next.
`define SGDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgdm assertion failed");

`endif

/* hw/rtl/sgdm_pkg.sv */
// Shared types and constants of the SGD momentum weight update block.
// No dependencies; used by sgdm_ram and sgd_momentum_weight_update.
package sgdm_pkg;

  localparam int ENTRIES_DEF     = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int FUNC_W    = 2;
  localparam int INDEX_W   = 10;
  localparam int OPERAND_W = 32;
  localparam int RESULT_W  = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // function codes
  localparam logic [FUNC_W-1:0] FN_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_UPDATE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;
  localparam logic [FUNC_W-1:0] FN_SPARE  = 2'd3;  // behaves as a read

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH      = 2'd3;

  localparam logic [CFG_W-1:0] LEARN_RATE_RST = 16'd655;
  localparam logic [CFG_W-1:0] MOMENTUM_RST   = 16'd58982;
  localparam logic [CFG_W-1:0] DECAY_RST      = 16'd0;
  localparam logic [CFG_W-1:0] BATCH_RST      = 16'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECAY_MUL,
    ST_DECAY_ADD,
    ST_MOM_MUL,
    ST_DIVIDE,
    ST_VEL_ADD,
    ST_LR_MUL,
    ST_WT_SUB,
    ST_FINISH
  } sgdm_state_t;

endpackage

/* hw/rtl/sgdm_ram.sv */
// Generic single-port RAM, write or registered read each cycle.
// Depends on sgdm_pkg for default sizes.
module sgdm_ram #(
  parameter int WIDTH = sgdm_pkg::VALUE_WIDTH_DEF,
  parameter int DEPTH = sgdm_pkg::ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* hw/rtl/sgd_momentum_weight_update.sv */
// SGD with momentum and L2 weight decay over a parameter store of weights and
// velocities (signed fixed point, 16 fraction bits). Depends on sgdm_pkg,
// sgdm_ram and assert_macros.svh.
// Input channel (item_valid/item_stall) carries func, entry_index and
// operand_value; the result channel (result_valid/result_stall) returns one
// transaction per input transaction: index, weight, velocity, saturated.
// One item is processed at a time; item_stall is low only while idle.
// The update uses the bit-serial divider (one quotient bit per cycle) and the
// shared 32x17 multiplier, which works on ceil(VALUE_WIDTH/32) chunks of 32
// bits and is used in turn three times when decay_factor is nonzero, else twice.
// The next item can be accepted in the cycle after the result is registered,
// while that result may still wait on result_stall; if the receiver stalls, a
// finished item holds in its last state until the output register frees up.
// Reset clears control state and loads the register defaults; the stores are
// not cleared, so an entry must be loaded before it is read or updated.
// Configuration writes (cfg_write/cfg_index/cfg_data) belong in idle time.
`include "assert_macros.svh"

module sgd_momentum_weight_update #(
  parameter int ENTRIES     = sgdm_pkg::ENTRIES_DEF,
  parameter int VALUE_WIDTH = sgdm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [sgdm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgdm_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [sgdm_pkg::FUNC_W-1:0]         func,
  input  logic [sgdm_pkg::INDEX_W-1:0]        entry_index,
  input  logic signed [sgdm_pkg::OPERAND_W-1:0] operand_value,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [sgdm_pkg::INDEX_W-1:0]        result_index,
  output logic signed [sgdm_pkg::RESULT_W-1:0] weight_out,
  output logic signed [sgdm_pkg::RESULT_W-1:0] velocity_out,
  output logic                                saturated
);

  localparam int VW      = VALUE_WIDTH;
  localparam int IW      = sgdm_pkg::INDEX_W;
  localparam int OW      = sgdm_pkg::OPERAND_W;
  localparam int RW      = sgdm_pkg::RESULT_W;
  localparam int CW      = sgdm_pkg::CFG_W;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int NCHUNK  = (VW + 31) / 32;
  localparam int MAG_W   = NCHUNK * 32;
  localparam int FAC_W   = CW + 1;
  localparam int PP_W    = 32 + FAC_W;
  localparam int ACC_W   = MAG_W + FAC_W;
  localparam int RND_W   = ACC_W - 16;
  localparam int STEP_W  = $clog2(VW + 2);

  localparam logic [STEP_W-1:0] STEP_PP_END  = STEP_W'(NCHUNK);
  localparam logic [STEP_W-1:0] STEP_ACC_END = STEP_W'(NCHUNK + 1);
  localparam logic [STEP_W-1:0] MUL_LAST     = STEP_W'(NCHUNK + 2);
  localparam logic [STEP_W-1:0] DIV_END      = STEP_W'(VW);
  localparam logic [STEP_W-1:0] DIV_LAST     = STEP_W'(VW + 1);
  localparam logic [STEP_W-1:0] STEP_ONE     = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_TWO     = STEP_W'(2);

  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [ACC_W-1:0]     RND_ONE = ACC_W'(1) << 15;

  // configuration
  logic [CW-1:0] learn_rate;
  logic [CW-1:0] momentum_factor;
  logic [CW-1:0] decay_factor;
  logic [CW-1:0] batch_count;

  sgdm_pkg::sgdm_state_t state, state_next;
  logic [STEP_W-1:0]     step, step_next;

  logic accept;
  logic out_free;
  logic load_out;

  // item registers
  logic [sgdm_pkg::FUNC_W-1:0] func_r;
  logic [IW-1:0]               idx_r;
  logic signed [VW-1:0]        g_r;
  logic signed [VW-1:0]        w_r;
  logic signed [VW-1:0]        v_r;
  logic signed [VW-1:0]        mul_res;
  logic signed [VW-1:0]        q_r;
  logic                        clip_r;

  // multiplier
  logic signed [VW-1:0] mul_x;
  logic [FAC_W-1:0]     mul_f;
  logic [VW-1:0]        mul_abs;
  logic [MAG_W-1:0]     m_mag;
  logic                 m_neg;
  logic [FAC_W-1:0]     m_fac;
  logic [PP_W-1:0]      pp_r;
  logic [ACC_W-1:0]     acc;
  logic [RND_W-1:0]     rnd;
  logic [RND_W-1:0]     rnd_hi;
  logic                 pos_ovf;
  logic                 neg_ovf;
  logic signed [VW-1:0] fit_val;
  logic                 fit_clip;

  // divider
  logic [VW-1:0] g_abs;
  logic [VW-1:0] d_quo;
  logic [CW-1:0] d_rem;
  logic [CW-1:0] d_div;
  logic          d_neg;
  logic [CW:0]   d_trial;
  logic          d_ge;

  // saturating adder
  logic signed [VW-1:0] add_a;
  logic signed [VW-1:0] add_b;
  logic                 add_sub;
  logic [VW:0]          add_res;

  // index wrap and operand width
  logic [31:0]          wrap_acc;
  logic [IW-1:0]        idx_wrap;
  logic [ADDR_W+IW-1:0] addr_in_ext;
  logic [ADDR_W+IW-1:0] addr_r_ext;
  logic [VW+OW-1:0]     opv_wide;
  logic signed [VW-1:0] opv_ext;
  logic [VW+RW-1:0]     w_ext;
  logic [VW+RW-1:0]     v_ext;

  // memories
  logic              ram_en;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [VW-1:0]     w_rd;
  logic [VW-1:0]     v_rd;

  function automatic logic [VW:0] sat_sum(input logic signed [VW-1:0] a,
                                          input logic signed [VW-1:0] b,
                                          input logic sub);
    logic signed [VW:0] s;
    logic [VW:0]        res;
    if (sub) begin
      s = (VW+1)'(a) - (VW+1)'(b);
    end else begin
      s = (VW+1)'(a) + (VW+1)'(b);
    end
    if (s[VW] != s[VW-1]) begin
      res = {1'b1, (s[VW] ? VAL_MIN : VAL_MAX)};
    end else begin
      res = {1'b0, s[VW-1:0]};
    end
    return res;
  endfunction

  assign item_stall = (state != sgdm_pkg::ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign load_out   = (state == sgdm_pkg::ST_FINISH) && out_free;

  // entry_index modulo ENTRIES by restoring subtraction
  always_comb begin
    wrap_acc = 32'(entry_index);
    for (int k = IW - 1; k >= 0; k--) begin
      if (wrap_acc >= (32'(ENTRIES) << k)) begin
        wrap_acc = wrap_acc - (32'(ENTRIES) << k);
      end
    end
    idx_wrap = wrap_acc[IW-1:0];
  end

  assign addr_in_ext = (ADDR_W+IW)'(idx_wrap);
  assign addr_r_ext  = (ADDR_W+IW)'(idx_r);
  assign opv_wide    = (VW+OW)'(operand_value);
  assign opv_ext     = opv_wide[VW-1:0];

  assign ram_en   = accept;
  assign ram_we   = load_out && (func_r == sgdm_pkg::FN_LOAD || func_r == sgdm_pkg::FN_UPDATE);
  assign ram_addr = accept ? addr_in_ext[ADDR_W-1:0] : addr_r_ext[ADDR_W-1:0];

  sgdm_ram #(.WIDTH(VW), .DEPTH(ENTRIES)) u_weight_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (w_r),
    .rdata (w_rd)
  );

  sgdm_ram #(.WIDTH(VW), .DEPTH(ENTRIES)) u_velocity_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (v_r),
    .rdata (v_rd)
  );

  // multiplier operand selection and result fitting
  always_comb begin
    case (state)
      sgdm_pkg::ST_DECAY_MUL: begin
        mul_x = w_r;
        mul_f = {decay_factor, 1'b0};
      end
      sgdm_pkg::ST_MOM_MUL: begin
        mul_x = v_r;
        mul_f = {1'b0, momentum_factor};
      end
      default: begin
        mul_x = v_r;
        mul_f = {1'b0, learn_rate};
      end
    endcase
  end

  assign mul_abs = mul_x[VW-1] ? VW'(-mul_x) : VW'(mul_x);
  assign rnd     = acc[ACC_W-1:16];
  assign rnd_hi  = rnd >> (VW - 1);
  assign pos_ovf = (rnd_hi != '0);
  assign neg_ovf = (rnd_hi > RND_W'(1)) || (rnd_hi == RND_W'(1) && rnd[VW-2:0] != '0);

  always_comb begin
    if (m_neg) begin
      fit_val  = neg_ovf ? VAL_MIN : VW'(-rnd[VW-1:0]);
      fit_clip = neg_ovf;
    end else begin
      fit_val  = pos_ovf ? VAL_MAX : rnd[VW-1:0];
      fit_clip = pos_ovf;
    end
  end

  assign g_abs   = g_r[VW-1] ? VW'(-g_r) : VW'(g_r);
  assign d_trial = {d_rem, d_quo[VW-1]};
  assign d_ge    = (d_trial >= {1'b0, d_div});

  always_comb begin
    case (state)
      sgdm_pkg::ST_DECAY_ADD: begin
        add_a   = g_r;
        add_b   = mul_res;
        add_sub = 1'b0;
      end
      sgdm_pkg::ST_VEL_ADD: begin
        add_a   = mul_res;
        add_b   = q_r;
        add_sub = 1'b0;
      end
      default: begin
        add_a   = w_r;
        add_b   = mul_res;
        add_sub = 1'b1;
      end
    endcase
  end

  assign add_res = sat_sum(add_a, add_b, add_sub);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate      <= sgdm_pkg::LEARN_RATE_RST;
      momentum_factor <= sgdm_pkg::MOMENTUM_RST;
      decay_factor    <= sgdm_pkg::DECAY_RST;
      batch_count     <= sgdm_pkg::BATCH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        sgdm_pkg::REG_LEARN_RATE: learn_rate      <= cfg_data;
        sgdm_pkg::REG_MOMENTUM:   momentum_factor <= cfg_data;
        sgdm_pkg::REG_DECAY:      decay_factor    <= cfg_data;
        sgdm_pkg::REG_BATCH:      batch_count     <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sgdm_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      sgdm_pkg::ST_IDLE: begin
        if (accept) state_next = sgdm_pkg::ST_FETCH;
      end
      sgdm_pkg::ST_FETCH: begin
        case (func_r)
          sgdm_pkg::FN_UPDATE: begin
            state_next = (decay_factor != '0) ? sgdm_pkg::ST_DECAY_MUL : sgdm_pkg::ST_MOM_MUL;
          end
          default: state_next = sgdm_pkg::ST_FINISH;
        endcase
      end
      sgdm_pkg::ST_DECAY_MUL, sgdm_pkg::ST_MOM_MUL, sgdm_pkg::ST_LR_MUL: begin
        if (step == MUL_LAST) begin
          step_next = '0;
          case (state)
            sgdm_pkg::ST_DECAY_MUL: state_next = sgdm_pkg::ST_DECAY_ADD;
            sgdm_pkg::ST_MOM_MUL:   state_next = sgdm_pkg::ST_DIVIDE;
            default:                state_next = sgdm_pkg::ST_WT_SUB;
          endcase
        end else begin
          step_next = step + STEP_ONE;
        end
      end
      sgdm_pkg::ST_DECAY_ADD: state_next = sgdm_pkg::ST_MOM_MUL;
      sgdm_pkg::ST_DIVIDE: begin
        if (step == DIV_LAST) begin
          step_next  = '0;
          state_next = sgdm_pkg::ST_VEL_ADD;
        end else begin
          step_next = step + STEP_ONE;
        end
      end
      sgdm_pkg::ST_VEL_ADD: state_next = sgdm_pkg::ST_LR_MUL;
      sgdm_pkg::ST_WT_SUB:  state_next = sgdm_pkg::ST_FINISH;
      sgdm_pkg::ST_FINISH: begin
        if (out_free) state_next = sgdm_pkg::ST_IDLE;
      end
      default: begin
        state_next = sgdm_pkg::ST_IDLE;
        step_next  = '0;
      end
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= func;
      idx_r  <= idx_wrap;
      g_r    <= opv_ext;
      clip_r <= 1'b0;
    end
    case (state)
      sgdm_pkg::ST_FETCH: begin
        case (func_r)
          sgdm_pkg::FN_LOAD: begin
            w_r <= g_r;
            v_r <= '0;
          end
          sgdm_pkg::FN_UPDATE, sgdm_pkg::FN_READ, sgdm_pkg::FN_SPARE: begin
            w_r <= w_rd;
            v_r <= v_rd;
          end
          default: ;
        endcase
      end
      sgdm_pkg::ST_DECAY_MUL, sgdm_pkg::ST_MOM_MUL, sgdm_pkg::ST_LR_MUL: begin
        if (step == '0) begin
          m_mag <= MAG_W'(mul_abs);
          m_neg <= mul_x[VW-1];
          m_fac <= mul_f;
          acc   <= '0;
        end else begin
          // top chunk first; rounding constant joins the last accumulate
          if (step <= STEP_PP_END) begin
            pp_r  <= m_mag[MAG_W-1 -: 32] * m_fac;
            m_mag <= m_mag << 32;
          end
          if (step >= STEP_TWO && step <= STEP_ACC_END) begin
            acc <= (acc << 32) + ACC_W'(pp_r) + ((step == STEP_ACC_END) ? RND_ONE : '0);
          end
          if (step == MUL_LAST) begin
            mul_res <= fit_val;
            clip_r  <= clip_r | fit_clip;
          end
        end
      end
      sgdm_pkg::ST_DECAY_ADD: begin
        g_r    <= add_res[VW-1:0];
        clip_r <= clip_r | add_res[VW];
      end
      sgdm_pkg::ST_DIVIDE: begin
        if (step == '0) begin
          d_quo <= g_abs;
          d_neg <= g_r[VW-1];
          d_rem <= '0;
          d_div <= (batch_count == '0) ? CW'(1) : batch_count;
        end else if (step <= DIV_END) begin
          d_rem <= d_ge ? CW'(d_trial - {1'b0, d_div}) : d_trial[CW-1:0];
          d_quo <= {d_quo[VW-2:0], d_ge};
        end else begin
          q_r <= d_neg ? VW'(-d_quo) : d_quo;
        end
      end
      sgdm_pkg::ST_VEL_ADD: begin
        v_r    <= add_res[VW-1:0];
        clip_r <= clip_r | add_res[VW];
      end
      sgdm_pkg::ST_WT_SUB: begin
        w_r    <= add_res[VW-1:0];
        clip_r <= clip_r | add_res[VW];
      end
      default: ;
    endcase
  end

  // output register
  assign w_ext = {{RW{1'b0}}, w_r};
  assign v_ext = {{RW{1'b0}}, v_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result_index <= idx_r;
      weight_out   <= w_ext[RW-1:0];
      velocity_out <= v_ext[RW-1:0];
      saturated    <= clip_r;
    end
  end

  `SGDM_ASSERT_NEXT(a_accept_fetch, clk, rst, accept, state == sgdm_pkg::ST_FETCH)
  `SGDM_ASSERT(a_flag_update_only, clk, rst, (load_out && func_r != sgdm_pkg::FN_UPDATE) |-> !clip_r)
  `SGDM_ASSERT(a_div_rem_bound, clk, rst, (state == sgdm_pkg::ST_DIVIDE && step != '0) |-> (d_rem < d_div))
  `SGDM_ASSERT_NEXT(a_result_index, clk, rst, load_out, result_valid && result_index == $past(idx_r))

endmodule

/* tb/sv/sgd_momentum_weight_update_test.sv */
// Self-checking bench for sgd_momentum_weight_update: a directed table, then
// random load/update/read traffic over several register settings, with results
// predicted in-bench. Depends on sgdm_pkg and the block's RTL.
`timescale 1ns / 1ps

module sgd_momentum_weight_update_test;
  import sgdm_pkg::*;

  localparam int  WATCHDOG_CYCLES = 2000;
  localparam int  HOLD_CYCLES     = 400;
  localparam int  DRAIN_CYCLES    = 60;
  localparam int  PHASE_ITEMS     = 210;
  localparam longint VAL_MAX      = 64'sd2147483647;
  localparam longint VAL_MIN      = -64'sd2147483648;

  typedef struct packed {
    logic [INDEX_W-1:0]  idx;
    logic [RESULT_W-1:0] w;
    logic [RESULT_W-1:0] v;
    logic                sat;
  } entry_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [FUNC_W-1:0]    sel;    // function code, or register index for ROW_CFG
    logic [INDEX_W-1:0]   idx;
    logic [OPERAND_W-1:0] value;
    logic                 typed;  // want holds a hand-written expectation
    entry_result_t        want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  logic [FUNC_W-1:0]      func = FN_READ;
  logic [INDEX_W-1:0]     entry_index = '0;
  logic signed [OPERAND_W-1:0] operand_value = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [INDEX_W-1:0]     result_index;
  logic signed [RESULT_W-1:0] weight_out;
  logic signed [RESULT_W-1:0] velocity_out;
  logic                   saturated;

  sgd_momentum_weight_update dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .entry_index  (entry_index),
    .operand_value(operand_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_index (result_index),
    .weight_out   (weight_out),
    .velocity_out (velocity_out),
    .saturated    (saturated)
  );

  // mirror of the parameter store and registers
  logic signed [RESULT_W-1:0] weight_mirror [1024];
  logic signed [RESULT_W-1:0] velocity_mirror [1024];
  logic [CFG_W-1:0] lr_cur    = LEARN_RATE_RST;
  logic [CFG_W-1:0] mom_cur   = MOMENTUM_RST;
  logic [CFG_W-1:0] decay_cur = DECAY_RST;
  logic [CFG_W-1:0] batch_cur = BATCH_RST;
  bit               clip_seen;

  entry_result_t pending_results[$];
  bit            loaded [1024];
  int            active[$];
  int            recent[$];
  int            mismatches = 0;
  int            gap_pct = 20;
  bit            quiet_tail = 1'b0;
  bit            long_hold = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------- fixed-point helpers ----------------

  function automatic longint fit_range(bit neg, longint unsigned mag);
    if (!neg) begin
      if (mag > VAL_MAX) begin
        clip_seen = 1'b1;
        return VAL_MAX;
      end
      return longint'(mag);
    end
    if (mag > 64'd2147483648) begin
      clip_seen = 1'b1;
      return VAL_MIN;
    end
    return -longint'(mag);
  endfunction

  // x * f / 2^16, round half away from zero
  function automatic longint frac_scale(longint x, int unsigned f);
    bit neg;
    longint unsigned mag;
    neg = x < 0;
    mag = neg ? longint'(-x) : longint'(x);
    return fit_range(neg, (mag * f + 64'd32768) >> 16);
  endfunction

  function automatic longint sum_sat(longint a, longint b);
    longint s;
    s = a + b;
    if (s > VAL_MAX) begin
      clip_seen = 1'b1;
      return VAL_MAX;
    end
    if (s < VAL_MIN) begin
      clip_seen = 1'b1;
      return VAL_MIN;
    end
    return s;
  endfunction

  function automatic longint quotient(longint x, int unsigned d);
    bit neg;
    longint unsigned mag;
    if (d == 0) d = 1;
    neg = x < 0;
    mag = neg ? longint'(-x) : longint'(x);
    return fit_range(neg, mag / d);
  endfunction

  // applies one transaction to the mirror and returns the entry afterwards
  function automatic entry_result_t momentum_step(logic [FUNC_W-1:0] code,
                                                  logic [INDEX_W-1:0] idx,
                                                  logic signed [OPERAND_W-1:0] opv);
    longint g, w, v;
    entry_result_t r;
    clip_seen = 1'b0;
    if (code == FN_LOAD) begin
      weight_mirror[idx]   = opv;
      velocity_mirror[idx] = '0;
    end else if (code == FN_UPDATE) begin
      w = weight_mirror[idx];
      v = velocity_mirror[idx];
      g = opv;
      if (decay_cur != 0) g = sum_sat(g, frac_scale(w, {decay_cur, 1'b0}));
      v = sum_sat(frac_scale(v, mom_cur), quotient(g, batch_cur));
      w = sum_sat(w, -frac_scale(v, lr_cur));
      weight_mirror[idx]   = w[RESULT_W-1:0];
      velocity_mirror[idx] = v[RESULT_W-1:0];
    end
    r.idx = idx;
    r.w   = weight_mirror[idx];
    r.v   = velocity_mirror[idx];
    r.sat = clip_seen;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic stim_row_t op_row(logic [FUNC_W-1:0] code, logic [INDEX_W-1:0] idx,
                                       logic [OPERAND_W-1:0] value);
    stim_row_t r;
    r = '0;
    r.kind  = ROW_ITEM;
    r.sel   = code;
    r.idx   = idx;
    r.value = value;
    return r;
  endfunction

  function automatic stim_row_t chk_row(logic [FUNC_W-1:0] code, logic [INDEX_W-1:0] idx,
                                        logic [OPERAND_W-1:0] value, logic [RESULT_W-1:0] w,
                                        logic [RESULT_W-1:0] v, logic sat);
    stim_row_t r;
    r = op_row(code, idx, value);
    r.typed = 1'b1;
    r.want  = '{idx: idx, w: w, v: v, sat: sat};
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] sel, logic [CFG_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind  = ROW_CFG;
    r.sel   = sel;
    r.value = data;
    return r;
  endfunction

  function automatic logic [OPERAND_W-1:0] rand_operand();
    logic [OPERAND_W-1:0] mag;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'hffff_ffff;
          default: return 32'h0;
        endcase
      end
      2: mag = $urandom_range(0, 1 << 26);
      default: mag = $urandom_range(0, 1 << 20);
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic offer(logic [FUNC_W-1:0] code, logic [INDEX_W-1:0] idx,
                       logic [OPERAND_W-1:0] value, logic typed, entry_result_t want);
    int gap;
    entry_result_t got;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid    <= 1'b1;
    func          <= code;
    entry_index   <= idx;
    operand_value <= value;
    do @(posedge clk); while (item_stall !== 1'b0);
    got = momentum_step(code, idx, value);
    pending_results.push_back(typed ? want : got);
    if (code == FN_LOAD) begin
      if (!loaded[idx]) begin
        loaded[idx] = 1'b1;
        active.push_back(idx);
      end
      recent.push_back(idx);
      if (recent.size() > 8) void'(recent.pop_front());
    end
  endtask

  // drop valid and wait until every outstanding result is back
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (sel)
      REG_LEARN_RATE: lr_cur    = data;
      REG_MOMENTUM:   mom_cur   = data;
      REG_DECAY:      decay_cur = data;
      REG_BATCH:      batch_cur = data;
      default: ;
    endcase
  endtask

  // ---------------- result side ----------------

  initial begin
    int stall_left;
    int mode_cnt;
    int stall_pct;
    stall_left = 0;
    mode_cnt   = 0;
    stall_pct  = 20;
    forever begin
      @(negedge clk);
      if (++mode_cnt == 64) begin
        mode_cnt = 0;
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 5;
          default: stall_pct = 25;
        endcase
      end
      if (long_hold) begin
        stall_left = HOLD_CYCLES;
        long_hold  = 1'b0;
      end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 14);
      end
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    entry_result_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result transaction, idx %0d", $time, result_index);
      end else begin
        want = pending_results.pop_front();
        if (result_index !== want.idx || weight_out !== want.w ||
            velocity_out !== want.v || saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch idx %0d w %h v %h sat %b, expected idx %0d w %h v %h sat %b",
                     $time, result_index, weight_out, velocity_out, saturated,
                     want.idx, want.w, want.v, want.sat);
        end
      end
    end
  end

  // ends the run if no transaction moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((item_valid === 1'b1 && item_stall === 1'b0) ||
          (result_valid === 1'b1 && result_stall === 1'b0))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------- main sequence ----------------

  initial begin
    stim_row_t dir_rows[$];
    stim_row_t r;
    int ph, n, pick;
    logic [FUNC_W-1:0] code;
    logic [INDEX_W-1:0] idx;
    logic [OPERAND_W-1:0] value;
    logic [CFG_W-1:0] lr_set [5];
    logic [CFG_W-1:0] mom_set [5];
    logic [CFG_W-1:0] decay_set [5];
    logic [CFG_W-1:0] batch_set [5];

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset register values first
    dir_rows.push_back(chk_row(FN_LOAD,   10'd0,    32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 1'b0));
    dir_rows.push_back(chk_row(FN_LOAD,   10'd1023, 32'h8000_0000, 32'h8000_0000, 32'h0, 1'b0));
    dir_rows.push_back(chk_row(FN_READ,   10'd0,    32'h0,         32'h7fff_ffff, 32'h0, 1'b0));
    dir_rows.push_back(chk_row(FN_SPARE,  10'd1023, 32'hffff_ffff, 32'h8000_0000, 32'h0, 1'b0));
    dir_rows.push_back(chk_row(FN_LOAD,   10'd5,    32'h0,         32'h0,         32'h0, 1'b0));
    dir_rows.push_back(chk_row(FN_UPDATE, 10'd5,    32'h0,         32'h0,         32'h0, 1'b0));
    // velocity runs into the positive and negative rails
    dir_rows.push_back(op_row(FN_UPDATE, 10'd0,    32'h7fff_ffff));
    dir_rows.push_back(op_row(FN_UPDATE, 10'd0,    32'h7fff_ffff));
    dir_rows.push_back(op_row(FN_UPDATE, 10'd1023, 32'h8000_0000));
    dir_rows.push_back(op_row(FN_UPDATE, 10'd1023, 32'h8000_0000));
    dir_rows.push_back(chk_row(FN_LOAD,  10'd682,  32'h5555_5555, 32'h5555_5555, 32'h0, 1'b0));
    dir_rows.push_back(chk_row(FN_LOAD,  10'd341,  32'haaaa_aaaa, 32'haaaa_aaaa, 32'h0, 1'b0));
    dir_rows.push_back(op_row(FN_UPDATE, 10'd682,  32'haaaa_aaaa));
    dir_rows.push_back(op_row(FN_UPDATE, 10'd341,  32'h5555_5555));
    // all factors at full scale, zero batch count treated as one
    dir_rows.push_back(reg_row(REG_LEARN_RATE, 16'hffff));
    dir_rows.push_back(reg_row(REG_MOMENTUM,   16'hffff));
    dir_rows.push_back(reg_row(REG_DECAY,      16'hffff));
    dir_rows.push_back(reg_row(REG_BATCH,      16'h0));
    dir_rows.push_back(chk_row(FN_LOAD,  10'd7,    32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 1'b0));
    dir_rows.push_back(op_row(FN_UPDATE, 10'd7,    32'h7fff_ffff));
    dir_rows.push_back(op_row(FN_UPDATE, 10'd1023, 32'h0));
    dir_rows.push_back(op_row(FN_UPDATE, 10'd5,    32'hffff_ffff));
    // factors at zero, largest batch
    dir_rows.push_back(reg_row(REG_LEARN_RATE, 16'h0));
    dir_rows.push_back(reg_row(REG_MOMENTUM,   16'h0));
    dir_rows.push_back(reg_row(REG_DECAY,      16'h0));
    dir_rows.push_back(reg_row(REG_BATCH,      16'hffff));
    dir_rows.push_back(op_row(FN_UPDATE, 10'd682,  32'h7fff_ffff));
    dir_rows.push_back(op_row(FN_UPDATE, 10'd341,  32'h8000_0000));
    dir_rows.push_back(op_row(FN_READ,   10'd7,    32'h1234_5678));

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_CFG) begin
        drain();
        write_reg(r.sel, r.value[CFG_W-1:0]);
      end else begin
        offer(r.sel, r.idx, r.value, r.typed, r.want);
      end
    end

    lr_set    = '{LEARN_RATE_RST, 16'hffff, 16'h0, 16'h0, 16'd3000};
    mom_set   = '{MOMENTUM_RST,   16'hffff, 16'h0, 16'h0, 16'd60000};
    decay_set = '{DECAY_RST,      16'hffff, 16'h0, 16'h0, 16'd100};
    batch_set = '{BATCH_RST,      16'hffff, 16'd1, 16'h0, 16'd4};
    lr_set[3]    = $urandom_range(0, 65535);
    mom_set[3]   = $urandom_range(0, 65535);
    decay_set[3] = $urandom_range(0, 65535);
    batch_set[4] = $urandom_range(2, 9);

    for (ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(REG_LEARN_RATE, lr_set[ph]);
      write_reg(REG_MOMENTUM,   mom_set[ph]);
      write_reg(REG_DECAY,      decay_set[ph]);
      write_reg(REG_BATCH,      batch_set[ph]);
      if (ph == 4) quiet_tail = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 15;
            default: gap_pct = 40;
          endcase
        end
        // result side backs up while items keep coming
        if (ph == 2 && n == 60) long_hold = 1'b1;
        pick  = $urandom_range(0, 99);
        value = rand_operand();
        if (active.size() == 0 || pick < 14) begin
          code = FN_LOAD;
          idx  = $urandom_range(0, 1023);
        end else begin
          if (recent.size() != 0 && $urandom_range(0, 3) != 0)
            idx = recent[$urandom_range(0, recent.size() - 1)];
          else
            idx = active[$urandom_range(0, active.size() - 1)];
          code = (pick < 80) ? FN_UPDATE : (pick < 95) ? FN_READ : FN_SPARE;
        end
        offer(code, idx, value, 1'b0, '0);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
